[rtl/lpld_pkg.sv]
// Package for the long-press level detector: shared widths, codes, reset values
// and the structs that pass between modules. No dependencies.
`default_nettype none

package lpld_pkg;

    localparam int MAX_LEVELS = 4;
    localparam int TIME_WIDTH = 32;
    localparam int THR_REGS   = 4;
    localparam int LVL_USE    = (MAX_LEVELS < THR_REGS) ? MAX_LEVELS : THR_REGS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DUR_W      = 32;
    localparam int LVL_W      = 3;

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [LVL_W-1:0]      t_level;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL = 3'd0,
        CFG_LEVEL_COUNT  = 3'd1,
        CFG_THR_ONE      = 3'd2,
        CFG_THR_TWO      = 3'd3,
        CFG_THR_THREE    = 3'd4,
        CFG_THR_FOUR     = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_CLEAR  = 1'b1
    } t_action;

    localparam logic   RST_ACTIVE_LEVEL = 1'b0;
    localparam t_level RST_LEVEL_COUNT  = 3'd4;
    localparam logic [CFG_DATA_W-1:0] RST_THR_ONE   = 32'd100;
    localparam logic [CFG_DATA_W-1:0] RST_THR_TWO   = 32'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_THR_THREE = 32'd3000;
    localparam logic [CFG_DATA_W-1:0] RST_THR_FOUR  = 32'd5000;

    typedef struct packed {
        logic                      active_level;
        t_level                    level_count;
        t_time [THR_REGS-1:0]      thr;
    } t_cfg;

    typedef struct packed {
        logic             released;
        logic [DUR_W-1:0] duration;
        t_level           level;
        logic             max_reached;
        logic             pressed;
    } t_result;

endpackage

`default_nettype wire

[rtl/long_press_level_detector_unit.sv]
// Top level of the long-press level detector: input register, result register
// and handshakes. Depends on lpld_pkg, lpld_cfg and lpld_core.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------
//   sample  | in        | i_valid / o_stall        | i_action, i_now_ms, i_pin_level
//   result  | out       | o_valid / i_stall        | o_released .. o_pressed
//   config  | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One request per cycle sustained unless i_stall holds a full result. A request is taken
// into the input register; the compare/subtract pass then runs from the input register into
// the result register. The press state updates in the same cycle the result register loads.
// Synchronous active-low reset clears handshake and press state; config goes to defaults.
// A stalled result holds the input register; o_stall rises only while both are full.
`default_nettype none

module long_press_level_detector_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_action,
    input  wire logic [lpld_pkg::TIME_WIDTH-1:0] i_now_ms,
    input  wire logic                            i_pin_level,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_released,
    output logic [lpld_pkg::DUR_W-1:0]           o_press_duration,
    output logic [lpld_pkg::LVL_W-1:0]           o_press_level,
    output logic                                 o_max_reached,
    output logic                                 o_pressed,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lpld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lpld_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    logic              r_action;
    lpld_pkg::t_time   r_now;
    logic              r_pin;
    logic              r_out_valid;
    lpld_pkg::t_result r_out;

    logic              w_advance;
    logic              w_take;
    lpld_pkg::t_cfg    w_cfg;
    lpld_pkg::t_result w_res;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !w_advance;
    assign w_take      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    lpld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lpld_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_action (r_action),
        .i_now    (r_now),
        .i_pin    (r_pin),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action <= i_action;
            r_now    <= i_now_ms;
            r_pin    <= i_pin_level;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_released       = r_out.released;
    assign o_press_duration = r_out.duration;
    assign o_press_level    = r_out.level;
    assign o_max_reached    = r_out.max_reached;
    assign o_pressed        = r_out.pressed;

    // a release always leaves the button seen as not pressed
    a_rel_not_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_released |-> !o_pressed)
        else $error("release reported while still pressed");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_press_level <= lpld_pkg::LVL_W'(lpld_pkg::LVL_USE))
        else $error("press level above thresholds in use");

    // a held request in the input register is not overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_now) && $stable(r_action))
        else $error("input register lost a pending request");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_action == lpld_pkg::ACT_CLEAR |=>
            o_valid && !o_released && o_press_level == '0 && !o_max_reached)
        else $error("clear did not reset level and flags");

endmodule

`default_nettype wire

[rtl/lpld_cfg.sv]
// Configuration register bank for the long-press level detector.
// Depends on lpld_pkg.
`default_nettype none

module lpld_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [lpld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lpld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lpld_pkg::t_cfg                       o_cfg
);

    logic                  r_active_level;
    lpld_pkg::t_level      r_level_count;
    lpld_pkg::t_time [lpld_pkg::THR_REGS-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= lpld_pkg::RST_ACTIVE_LEVEL;
            r_level_count  <= lpld_pkg::RST_LEVEL_COUNT;
            r_thr[0]       <= lpld_pkg::TIME_WIDTH'(lpld_pkg::RST_THR_ONE);
            r_thr[1]       <= lpld_pkg::TIME_WIDTH'(lpld_pkg::RST_THR_TWO);
            r_thr[2]       <= lpld_pkg::TIME_WIDTH'(lpld_pkg::RST_THR_THREE);
            r_thr[3]       <= lpld_pkg::TIME_WIDTH'(lpld_pkg::RST_THR_FOUR);
        end else if (i_cfg_valid) begin
            unique case (lpld_pkg::t_cfg_idx'(i_cfg_index))
                lpld_pkg::CFG_ACTIVE_LEVEL: r_active_level <= i_cfg_data[0];
                lpld_pkg::CFG_LEVEL_COUNT:  r_level_count <= i_cfg_data[lpld_pkg::LVL_W-1:0];
                lpld_pkg::CFG_THR_ONE:   r_thr[0] <= lpld_pkg::TIME_WIDTH'(i_cfg_data);
                lpld_pkg::CFG_THR_TWO:   r_thr[1] <= lpld_pkg::TIME_WIDTH'(i_cfg_data);
                lpld_pkg::CFG_THR_THREE: r_thr[2] <= lpld_pkg::TIME_WIDTH'(i_cfg_data);
                lpld_pkg::CFG_THR_FOUR:  r_thr[3] <= lpld_pkg::TIME_WIDTH'(i_cfg_data);
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg.active_level = r_active_level;
    assign o_cfg.level_count  = r_level_count;
    assign o_cfg.thr          = r_thr;

endmodule

`default_nettype wire

[rtl/lpld_core.sv]
// Press tracking state and next-state logic: edge detection, duration,
// threshold compares and sticky max flag. Depends on lpld_pkg.
`default_nettype none

module lpld_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic                 i_action,
    input  wire lpld_pkg::t_time      i_now,
    input  wire logic                 i_pin,
    input  wire lpld_pkg::t_cfg       i_cfg,
    output lpld_pkg::t_result         o_res
);

    logic             r_held, n_held;
    logic             r_timing, n_timing;
    lpld_pkg::t_time  r_start, n_start;
    lpld_pkg::t_time  r_dur, n_dur;
    lpld_pkg::t_level r_level, n_level;
    logic             r_max, n_max;

    logic             w_p;
    logic             w_rel;
    lpld_pkg::t_time  w_elapsed;
    lpld_pkg::t_level w_n_use;
    lpld_pkg::t_level w_cand;

    // thresholds in use: limited by the available registers
    assign w_n_use = (i_cfg.level_count > lpld_pkg::LVL_W'(lpld_pkg::LVL_USE))
                   ? lpld_pkg::LVL_W'(lpld_pkg::LVL_USE) : i_cfg.level_count;

    always_comb begin
        n_held    = r_held;
        n_timing  = r_timing;
        n_start   = r_start;
        n_dur     = r_dur;
        n_level   = r_level;
        n_max     = r_max;
        w_rel     = 1'b0;
        w_p       = (i_pin == i_cfg.active_level);
        w_cand    = '0;
        w_elapsed = '0;
        if (lpld_pkg::t_action'(i_action) == lpld_pkg::ACT_CLEAR) begin
            n_level = '0;
            n_dur   = '0;
            n_max   = 1'b0;
        end else begin
            if (w_p != r_held) begin
                n_held = w_p;
                if (w_p) begin
                    n_start  = i_now;
                    n_timing = 1'b1;
                end else if (r_timing) begin
                    n_dur    = i_now - r_start;
                    n_timing = 1'b0;
                    w_rel    = 1'b1;
                end
            end
            w_elapsed = i_now - n_start;
            // parallel compares; the highest elapsed index wins
            for (int i = 0; i < lpld_pkg::LVL_USE; i++) begin
                if (lpld_pkg::LVL_W'(i) < w_n_use && w_elapsed >= i_cfg.thr[i]) begin
                    w_cand = lpld_pkg::LVL_W'(i + 1);
                end
            end
            if (!w_rel && n_held && n_timing) begin
                if (w_cand > r_level) begin
                    n_level = w_cand;
                end
                if (n_level == i_cfg.level_count) begin
                    n_max = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 1'b0;
            r_timing <= 1'b0;
            r_start  <= '0;
            r_dur    <= '0;
            r_level  <= '0;
            r_max    <= 1'b0;
        end else if (i_step) begin
            r_held   <= n_held;
            r_timing <= n_timing;
            r_start  <= n_start;
            r_dur    <= n_dur;
            r_level  <= n_level;
            r_max    <= n_max;
        end
    end

    assign o_res.released    = w_rel;
    assign o_res.duration    = lpld_pkg::DUR_W'(n_dur);
    assign o_res.level       = n_level;
    assign o_res.max_reached = n_max;
    assign o_res.pressed     = n_held;

endmodule

`default_nettype wire
